// ===== hdl/bounded_sorted_set_map_macros.svh =====
// Assertion macros used by the checker file.
`ifndef BOUNDED_SORTED_SET_MAP_MACROS_SVH
`define BOUNDED_SORTED_SET_MAP_MACROS_SVH

// Same-cycle property, sampled on clk, off while in reset.
`define BSSM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle property, sampled on clk, off while in reset.
`define BSSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/bssm_pkg.sv =====
`timescale 1ns / 1ps

package bssm_pkg;

  localparam int NODE_W   = 10;
  localparam int GROUP_W  = 32;
  localparam int COUNT_W  = 5;
  localparam int ACTION_W = 2;

  // in_tdata: node, group, zero fill to whole bytes
  localparam int IN_DATA_W  = 48;
  // out_tdata: ok, found, count, zero fill
  localparam int OUT_DATA_W = 8;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT   = 2'd0,
    ACT_REMOVE   = 2'd1,
    ACT_CONTAINS = 2'd2,
    ACT_SHARES   = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

endpackage

// ===== hdl/bounded_sorted_set_map.sv =====
`timescale 1ns / 1ps

// Per-node bounded sorted set of 32-bit group indices.
// Input channel in_*: one command per transfer. in_tuser carries the action
// (insert, remove, contains, shares element), in_tdata the node and group,
// in_tlast marks the final element of a shares query list.
// Output channel out_*: exactly one result per command (ok, found, count).
// Each node's set lives in one memory row (MAX_SET slots plus its size).
// A command reads the row, then one shared 32-bit comparator walks the slots
// one per cycle until it reaches the insert/remove position; for a successful
// insert or remove the row is then shifted in parallel and written back while
// the result is registered. A node out of range skips the walk. in_tready is
// high only while the block is idle, so a new command is taken only after the
// last result has been registered.
// Reset: a clearing pass zeroes every row, one per cycle, with in_tready low.
// If the receiver stalls, the finished result holds in the output register;
// a following command runs up to its write-back and waits there until the
// output register is free.
module bounded_sorted_set_map
  import bssm_pkg::*;
#(
  parameter int NUM_NODES = 1024,
  parameter int MAX_SET   = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [9:0] node, [41:10] group, [47:42] zero
  input  logic [ACTION_W-1:0]   in_tuser,   // [1:0] action
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // [0] ok, [1] found, [6:2] count, [7] zero
);

  localparam int ADDR_W = (NUM_NODES > 1) ? $clog2(NUM_NODES) : 1;
  localparam int SZ_W   = $clog2(MAX_SET + 1);
  localparam int IDX_W  = (MAX_SET > 1) ? $clog2(MAX_SET) : 1;
  localparam int SLOTS_W = MAX_SET * GROUP_W;
  localparam int ROW_W  = SLOTS_W + SZ_W;

  state_t state_r, state_nxt;

  logic [ROW_W-1:0] mem [NUM_NODES];
  logic [ROW_W-1:0] rd_q;
  logic             rd_en, wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [ROW_W-1:0]  wr_data;

  logic [ADDR_W-1:0] clr_r;
  action_t           act_r;
  logic              node_ok_r;
  logic [ADDR_W-1:0] addr_r;
  logic [GROUP_W-1:0] grp_r;
  logic              last_r;
  logic [SZ_W-1:0]   pos_r;
  logic              hit_r;
  logic              qhit_r;
  logic              out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;

  logic [NODE_W-1:0]  in_node;
  logic [GROUP_W-1:0] in_group;
  logic [31:0]        node_ext;
  logic               in_node_ok;
  logic               accept;

  logic [GROUP_W-1:0] row_s [MAX_SET];
  logic [GROUP_W-1:0] row_new [MAX_SET];
  logic [SLOTS_W-1:0] slots_new;
  logic [SZ_W-1:0]    size_q, size_new;
  logic [GROUP_W-1:0] cur_slot;
  logic               at_end, scan_stop;
  logic               ok, found, done_fire;
  logic [31:0]        cnt_ext;

  assign in_node  = in_tdata[NODE_W-1:0];
  assign in_group = in_tdata[NODE_W +: GROUP_W];
  assign node_ext = 32'(in_node);
  assign in_node_ok = (node_ext < 32'(NUM_NODES));
  assign in_tready = (state_r == ST_IDLE);
  assign accept = in_tvalid && in_tready;
  assign rd_en = accept;

  // row unpack
  always_comb begin
    for (int k = 0; k < MAX_SET; k++) begin
      row_s[k] = rd_q[k*GROUP_W +: GROUP_W];
    end
  end
  assign size_q = rd_q[ROW_W-1 -: SZ_W];

  // shared comparator, one slot per cycle
  assign cur_slot  = row_s[pos_r[IDX_W-1:0]];
  assign at_end    = (pos_r == size_q);
  assign scan_stop = at_end || (cur_slot >= grp_r);

  // parallel shift for insert/remove; unused slots are zero
  always_comb begin
    for (int k = 0; k < MAX_SET; k++) begin
      if (act_r == ACT_INSERT) begin
        if (SZ_W'(k) < pos_r)
          row_new[k] = row_s[k];
        else if (SZ_W'(k) == pos_r)
          row_new[k] = grp_r;
        else
          row_new[k] = row_s[(k > 0) ? k - 1 : 0];
      end else begin
        if (SZ_W'(k) < pos_r)
          row_new[k] = row_s[k];
        else if (k + 1 < MAX_SET)
          row_new[k] = row_s[(k + 1 < MAX_SET) ? k + 1 : k];
        else
          row_new[k] = '0;
      end
      slots_new[k*GROUP_W +: GROUP_W] = row_new[k];
    end
  end

  always_comb begin
    ok = 1'b0;
    found = 1'b0;
    size_new = size_q;
    case (act_r)
      ACT_INSERT: begin
        ok = node_ok_r && (size_q < SZ_W'(MAX_SET)) && !hit_r;
        if (ok) size_new = size_q + SZ_W'(1);
      end
      ACT_REMOVE: begin
        ok = node_ok_r && hit_r;
        if (ok) size_new = size_q - SZ_W'(1);
      end
      ACT_CONTAINS: found = node_ok_r && hit_r;
      ACT_SHARES:   found = qhit_r || (node_ok_r && hit_r);
      default: ;
    endcase
  end

  assign cnt_ext   = node_ok_r ? 32'(size_new) : 32'd0;
  assign done_fire = (state_r == ST_DONE) && (!out_tvalid_r || out_tready);

  // memory write mux: clearing pass or write-back
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = addr_r;
    wr_data = {size_new, slots_new};
    if (state_r == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_r;
      wr_data = '0;
    end else if (done_fire && ok) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem[node_ext[ADDR_W-1:0]];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_r == ADDR_W'(NUM_NODES - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (accept) state_nxt = in_node_ok ? ST_SCAN : ST_DONE;
      ST_SCAN:  if (scan_stop) state_nxt = ST_DONE;
      ST_DONE:  if (done_fire) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_r        <= '0;
      qhit_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_r <= clr_r + ADDR_W'(1);
      if (done_fire) begin
        out_tvalid_r <= 1'b1;
        if (act_r == ACT_SHARES) qhit_r <= last_r ? 1'b0 : found;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r     <= action_t'(in_tuser);
      node_ok_r <= in_node_ok;
      addr_r    <= node_ext[ADDR_W-1:0];
      grp_r     <= in_group;
      last_r    <= in_tlast;
      pos_r     <= '0;
      hit_r     <= 1'b0;
    end else if (state_r == ST_SCAN) begin
      if (scan_stop)
        hit_r <= !at_end && (cur_slot == grp_r);
      else
        pos_r <= pos_r + SZ_W'(1);
    end
    if (done_fire)
      out_tdata_r <= {1'b0, cnt_ext[COUNT_W-1:0], found, ok};
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

// ===== hdl/bssm_checker.sv =====
`timescale 1ns / 1ps
`include "bounded_sorted_set_map_macros.svh"

module bssm_checker
  import bssm_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata   // [0] ok, [1] found, [6:2] count, [7] zero
);

  // a stalled result holds
  `BSSM_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")

  // one command at a time: busy right after an input transfer
  `BSSM_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "input accepted back to back")

  // ok belongs to insert/remove, found to contains/shares
  `BSSM_ASSERT_NOW(a_ok_found_excl, out_tvalid, !(out_tdata[0] && out_tdata[1]), "ok and found both set")

  // fill bit stays zero
  `BSSM_ASSERT_NOW(a_pad_zero, out_tvalid, !out_tdata[7], "nonzero padding in result")

endmodule

bind bounded_sorted_set_map bssm_checker u_bssm_checker (.*);
